>>> src/bftcp_pkg.sv
// Shared types, constants and helpers for the box face tile card placement block.
`default_nettype none

package bftcp_pkg;

	localparam int unsigned DIV_W      = 48;
	localparam int unsigned DIV_STEP   = 4;
	localparam int unsigned DIV_STAGES = DIV_W / DIV_STEP;
	localparam int unsigned GRID_DEN_W = 9;
	localparam int unsigned EXT_W      = 24;

	localparam logic [14:0] INSET_MIN    = 15'd1311;
	localparam logic [14:0] INSET_MAX    = 15'd26214;
	localparam logic [32:0] INSET_BIG_DN = 33'd436917;
	localparam logic [22:0] INSET_RECIP  = 23'd8053065;
	localparam logic [31:0] EDGE_MIN     = 32'd66;
	localparam logic [23:0] EXT_MIN      = 24'd16384;
	localparam logic [30:0] HALF_MAX     = 31'h7FFF_FFFF;

	localparam logic [0:0] REG_CARD_EXT_LIMIT = 1'b0;
	localparam logic [0:0] REG_MAX_TILES_AXIS = 1'b1;

	localparam logic [2:0] DIR_POS_X = 3'd0;
	localparam logic [2:0] DIR_NEG_X = 3'd1;
	localparam logic [2:0] DIR_POS_Y = 3'd2;
	localparam logic [2:0] DIR_NEG_Y = 3'd3;
	localparam logic [2:0] DIR_POS_Z = 3'd4;
	localparam logic [2:0] DIR_NEG_Z = 3'd5;

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] min_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic signed [31:0] max_z;
		logic [2:0]         face;
		logic [7:0]         tile_u;
		logic [7:0]         tile_v;
		logic [7:0]         grid_u;
		logic [7:0]         grid_v;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [30:0]        half_u;
		logic [30:0]        half_v;
		logic [2:0]         normal_axis;
		logic [2:0]         tangent_axis;
		logic [2:0]         bitangent_axis;
		logic [7:0]         need_u;
		logic [7:0]         need_v;
	} out_item_t;

	typedef struct packed {
		logic [2:0] nc;
		logic [2:0] tc;
		logic [2:0] bc;
	} axes_t;

	function automatic axes_t decode_face(input logic [2:0] face);
		axes_t a;
		unique case (face)
			3'd0: a = '{nc: DIR_POS_X, tc: DIR_POS_Z, bc: DIR_POS_Y};
			3'd1: a = '{nc: DIR_NEG_X, tc: DIR_NEG_Z, bc: DIR_POS_Y};
			3'd2: a = '{nc: DIR_POS_Y, tc: DIR_POS_X, bc: DIR_POS_Z};
			3'd3: a = '{nc: DIR_NEG_Y, tc: DIR_POS_X, bc: DIR_NEG_Z};
			3'd4: a = '{nc: DIR_POS_Z, tc: DIR_NEG_X, bc: DIR_POS_Y};
			default: a = '{nc: DIR_NEG_Z, tc: DIR_POS_X, bc: DIR_POS_Y};
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -48'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/bftcp_if.sv
// Valid/ready channel interfaces for input and result beats.
`default_nettype none

interface bftcp_in_if;
	logic                 valid;
	logic                 ready;
	bftcp_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bftcp_out_if;
	logic                 valid;
	logic                 ready;
	bftcp_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/bftcp_div.sv
// Pipelined restoring divider, a fixed number of quotient bits per stage.
`default_nettype none

module bftcp_div #(
	parameter int unsigned DEN_W = bftcp_pkg::GRID_DEN_W
) (
	input  wire logic                                clk,
	input  wire logic [bftcp_pkg::DIV_STAGES-1:0]   en,
	input  wire logic [bftcp_pkg::DIV_W-1:0]        num,
	input  wire logic [DEN_W-1:0]                   den,
	output logic      [bftcp_pkg::DIV_W-1:0]        quo
);
	import bftcp_pkg::*;

	logic [DIV_W-1:0] nq_s  [DIV_STAGES];
	logic [DEN_W-1:0] rem_s [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES];
	logic [DIV_W-1:0] nq_n  [DIV_STAGES];
	logic [DEN_W-1:0] rem_n [DIV_STAGES];
	logic [DEN_W-1:0] den_n [DIV_STAGES];

	always_comb begin
		logic [DIV_W-1:0] nq;
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] d;
		logic [DEN_W:0]   t;
		for (int k = 0; k < int'(DIV_STAGES); k++) begin
			if (k == 0) begin
				nq  = num;
				rem = '0;
				d   = den;
			end else begin
				nq  = nq_s[k-1];
				rem = rem_s[k-1];
				d   = den_s[k-1];
			end
			for (int j = 0; j < int'(DIV_STEP); j++) begin
				t  = {rem, nq[DIV_W-1]};
				nq = {nq[DIV_W-2:0], 1'b0};
				if (t >= {1'b0, d}) begin
					t     = t - {1'b0, d};
					nq[0] = 1'b1;
				end
				rem = t[DEN_W-1:0];
			end
			nq_n[k]  = nq;
			rem_n[k] = rem;
			den_n[k] = d;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < int'(DIV_STAGES); k++) begin
			if (en[k]) begin
				nq_s[k]  <= nq_n[k];
				rem_s[k] <= rem_n[k];
				den_s[k] <= den_n[k];
			end
		end
	end

	assign quo = nq_s[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> src/box_face_tile_card_placement.sv
// Top level: box face tile card placement pipeline with APB configuration.
// One box face is taken per clock when the first stage is free; its result beat
// passes three setup stages, twelve divider stages and one output register. The
// depth is set by the long division of 48-bit dividends by the grid size and by the
// card extent, four quotient bits per stage. Every stage holds independently, so
// bubbles close up and an input beat is taken whenever the first stage is free.
// Registers: card extent limit at byte address 0, tile limit per axis at 4; write
// them only while no beat is in flight.
`default_nettype none

module box_face_tile_card_placement (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	bftcp_in_if.sink         in_ch,
	bftcp_out_if.source      out_ch
);
	import bftcp_pkg::*;

	localparam int unsigned LAST_S = DIV_STAGES + 4;

	typedef struct packed {
		logic               neg_t;
		logic               neg_b;
		logic               hz_u;
		logic               hz_v;
		logic signed [31:0] rn;
		logic [2:0]         nc;
		logic [2:0]         tc;
		logic [2:0]         bc;
	} side_t;

	// configuration
	logic [EXT_W-1:0] ext_q;
	logic [7:0]       tiles_q;
	logic [EXT_W-1:0] ext_eff;
	logic [7:0]       lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q   <= 24'd65536;
			tiles_q <= 8'd8;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_CARD_EXT_LIMIT: ext_q   <= pwdata[EXT_W-1:0];
				REG_MAX_TILES_AXIS: tiles_q <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CARD_EXT_LIMIT: prdata = {8'b0, ext_q};
			REG_MAX_TILES_AXIS: prdata = {24'b0, tiles_q};
		endcase
	end

	assign pready  = 1'b1;
	assign ext_eff = (ext_q < EXT_MIN) ? EXT_MIN : ext_q;
	assign lim     = (tiles_q == 8'd0) ? 8'd1 : tiles_q;

	// stage enables and valid bits
	logic [LAST_S:1] en;
	logic [LAST_S:1] vld_q;

	always_comb begin
		en[LAST_S] = !vld_q[LAST_S] || out_ch.ready;
		for (int k = int'(LAST_S) - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_ch.valid;
			end
			for (int k = 2; k <= int'(LAST_S); k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ch.ready = en[1];

	// stage 1: sums, differences, face decode
	logic signed [32:0] s_all [3];
	logic signed [32:0] d_all [3];
	axes_t              ax;
	logic signed [32:0] sn_c, st_c, sb_c, dn_c, du_c, dv_c;

	always_comb begin
		s_all[0] = 33'(in_ch.data.min_x) + 33'(in_ch.data.max_x);
		s_all[1] = 33'(in_ch.data.min_y) + 33'(in_ch.data.max_y);
		s_all[2] = 33'(in_ch.data.min_z) + 33'(in_ch.data.max_z);
		d_all[0] = 33'(in_ch.data.max_x) - 33'(in_ch.data.min_x);
		d_all[1] = 33'(in_ch.data.max_y) - 33'(in_ch.data.min_y);
		d_all[2] = 33'(in_ch.data.max_z) - 33'(in_ch.data.min_z);
		ax = decode_face(in_ch.data.face);
		unique case (ax.nc[2:1])
			2'd0:    begin sn_c = s_all[0]; dn_c = d_all[0]; end
			2'd1:    begin sn_c = s_all[1]; dn_c = d_all[1]; end
			default: begin sn_c = s_all[2]; dn_c = d_all[2]; end
		endcase
		unique case (ax.tc[2:1])
			2'd0:    begin st_c = s_all[0]; du_c = d_all[0]; end
			2'd1:    begin st_c = s_all[1]; du_c = d_all[1]; end
			default: begin st_c = s_all[2]; du_c = d_all[2]; end
		endcase
		unique case (ax.bc[2:1])
			2'd0:    begin sb_c = s_all[0]; dv_c = d_all[0]; end
			2'd1:    begin sb_c = s_all[1]; dv_c = d_all[1]; end
			default: begin sb_c = s_all[2]; dv_c = d_all[2]; end
		endcase
	end

	logic signed [32:0] sn_s1, st_s1, sb_s1, dn_s1, du_s1, dv_s1;
	logic [7:0]         gu_s1, gv_s1, tu_s1, tv_s1;
	axes_t              ax_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sn_s1 <= sn_c;
			st_s1 <= st_c;
			sb_s1 <= sb_c;
			dn_s1 <= dn_c;
			du_s1 <= du_c;
			dv_s1 <= dv_c;
			gu_s1 <= (in_ch.data.grid_u == 8'd0) ? 8'd1 : in_ch.data.grid_u;
			gv_s1 <= (in_ch.data.grid_v == 8'd0) ? 8'd1 : in_ch.data.grid_v;
			tu_s1 <= in_ch.data.tile_u;
			tv_s1 <= in_ch.data.tile_v;
			ax_s1 <= ax;
		end
	end

	// stage 2: products, inset scaling, half and tile dividends
	logic signed [9:0]  ku_c, kv_c;
	logic [31:0]        len_u, len_v;

	assign ku_c  = $signed({1'b0, tu_s1, 1'b1}) - $signed({2'b0, gu_s1});
	assign kv_c  = $signed({1'b0, tv_s1, 1'b1}) - $signed({2'b0, gv_s1});
	assign len_u = (du_s1 < 33'sd66) ? EDGE_MIN : du_s1[31:0];
	assign len_v = (dv_s1 < 33'sd66) ? EDGE_MIN : dv_s1[31:0];

	logic signed [41:0] pt_s2, pb_s2;
	logic signed [42:0] qt_s2, qb_s2;
	logic [41:0]        prod_s2;
	logic               dnpos_s2, dnbig_s2;
	logic signed [32:0] sn_s2, dn_s2;
	logic [32:0]        hnu_s2, hnv_s2, tnu_s2, tnv_s2;
	logic               hzu_s2, hzv_s2;
	logic [7:0]         gu_s2, gv_s2;
	axes_t              ax_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pt_s2    <= 42'($signed(st_s1) * $signed({1'b0, gu_s1}));
			pb_s2    <= 42'($signed(sb_s1) * $signed({1'b0, gv_s1}));
			qt_s2    <= 43'($signed(du_s1) * ku_c);
			qb_s2    <= 43'($signed(dv_s1) * kv_c);
			prod_s2  <= 42'(dn_s1[18:0]) * 42'(INSET_RECIP);
			dnpos_s2 <= dn_s1 > 33'sd0;
			dnbig_s2 <= dn_s1 >= $signed(INSET_BIG_DN);
			sn_s2    <= sn_s1;
			dn_s2    <= dn_s1;
			hnu_s2   <= $unsigned(du_s1) + {25'b0, gu_s1};
			hnv_s2   <= $unsigned(dv_s1) + {25'b0, gv_s1};
			hzu_s2   <= !(du_s1 > 33'sd0);
			hzv_s2   <= !(dv_s1 > 33'sd0);
			tnu_s2   <= 33'(len_u) + 33'(ext_eff) - 33'd1;
			tnv_s2   <= 33'(len_v) + 33'(ext_eff) - 33'd1;
			gu_s2    <= gu_s1;
			gv_s2    <= gv_s1;
			ax_s2    <= ax_s1;
		end
	end

	// stage 3: origin dividends, inset and normal offset
	logic [14:0]        q_inset, inset;
	logic signed [33:0] off_diff;

	always_comb begin
		q_inset = prod_s2[41:27];
		if (!dnpos_s2) begin
			inset = INSET_MIN;
		end else if (dnbig_s2) begin
			inset = INSET_MAX;
		end else if (q_inset < INSET_MIN) begin
			inset = INSET_MIN;
		end else begin
			inset = q_inset;
		end
		off_diff = 34'(dn_s2) - 34'($signed({1'b0, inset, 1'b0}));
	end

	logic signed [45:0] nt_s3, nb_s3;
	logic [32:0]        off2_s3;
	logic signed [32:0] sn_s3;
	logic [32:0]        hnu_s3, hnv_s3, tnu_s3, tnv_s3;
	logic               hzu_s3, hzv_s3;
	logic [7:0]         gu_s3, gv_s3;
	axes_t              ax_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			nt_s3   <= 46'(pt_s2) + (ax_s2.tc[0] ? -46'(qt_s2) : 46'(qt_s2))
			           + 46'($signed({1'b0, gu_s2}));
			nb_s3   <= 46'(pb_s2) + (ax_s2.bc[0] ? -46'(qb_s2) : 46'(qb_s2))
			           + 46'($signed({1'b0, gv_s2}));
			off2_s3 <= off_diff[33] ? 33'd0 : off_diff[32:0];
			sn_s3   <= sn_s2;
			hnu_s3  <= hnu_s2;
			hnv_s3  <= hnv_s2;
			hzu_s3  <= hzu_s2;
			hzv_s3  <= hzv_s2;
			tnu_s3  <= tnu_s2;
			tnv_s3  <= tnv_s2;
			gu_s3   <= gu_s2;
			gv_s3   <= gv_s2;
			ax_s3   <= ax_s2;
		end
	end

	// divider inputs and side data
	logic [DIV_W-1:0]      ntx, nbx, mag_t, mag_b;
	logic [GRID_DEN_W-1:0] dt, db;
	logic signed [34:0]    rn_sum;
	logic signed [33:0]    rn_half;
	side_t                 side_in;

	always_comb begin
		ntx   = DIV_W'(nt_s3);
		nbx   = DIV_W'(nb_s3);
		dt    = {gu_s3, 1'b0};
		db    = {gv_s3, 1'b0};
		mag_t = nt_s3[45] ? ~ntx + DIV_W'(dt) : ntx;
		mag_b = nb_s3[45] ? ~nbx + DIV_W'(db) : nbx;
		rn_sum = 35'(sn_s3) + (ax_s3.nc[0] ? -35'($signed({2'b0, off2_s3}))
		                                   : 35'($signed({2'b0, off2_s3}))) + 35'sd1;
		rn_half = rn_sum[34:1];
		side_in.neg_t = nt_s3[45];
		side_in.neg_b = nb_s3[45];
		side_in.hz_u  = hzu_s3;
		side_in.hz_v  = hzv_s3;
		side_in.rn    = sat32(48'(rn_half));
		side_in.nc    = ax_s3.nc;
		side_in.tc    = ax_s3.tc;
		side_in.bc    = ax_s3.bc;
	end

	side_t side_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			side_s[0] <= side_in;
		end
		for (int k = 1; k < int'(DIV_STAGES); k++) begin
			if (en[k+4]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	logic [DIV_W-1:0] quo_t, quo_b, quo_hu, quo_hv, quo_nu, quo_nv;

	bftcp_div #(.DEN_W(GRID_DEN_W)) u_div_t (
		.clk(clk), .en(en[LAST_S-1:4]), .num(mag_t), .den(dt), .quo(quo_t));
	bftcp_div #(.DEN_W(GRID_DEN_W)) u_div_b (
		.clk(clk), .en(en[LAST_S-1:4]), .num(mag_b), .den(db), .quo(quo_b));
	bftcp_div #(.DEN_W(GRID_DEN_W)) u_div_hu (
		.clk(clk), .en(en[LAST_S-1:4]), .num(DIV_W'(hnu_s3)), .den(dt), .quo(quo_hu));
	bftcp_div #(.DEN_W(GRID_DEN_W)) u_div_hv (
		.clk(clk), .en(en[LAST_S-1:4]), .num(DIV_W'(hnv_s3)), .den(db), .quo(quo_hv));
	bftcp_div #(.DEN_W(EXT_W)) u_div_nu (
		.clk(clk), .en(en[LAST_S-1:4]), .num(DIV_W'(tnu_s3)), .den(ext_eff), .quo(quo_nu));
	bftcp_div #(.DEN_W(EXT_W)) u_div_nv (
		.clk(clk), .en(en[LAST_S-1:4]), .num(DIV_W'(tnv_s3)), .den(ext_eff), .quo(quo_nv));

	// output stage: sign fix, saturate, route by axis
	side_t              sd;
	logic signed [31:0] rt, rb;
	logic signed [31:0] org [3];
	out_item_t          res;

	always_comb begin
		sd = side_s[DIV_STAGES-1];
		rt = sat32(sd.neg_t ? -$signed(quo_t) : $signed(quo_t));
		rb = sat32(sd.neg_b ? -$signed(quo_b) : $signed(quo_b));
		for (int a = 0; a < 3; a++) begin
			if (sd.nc[2:1] == 2'(a)) begin
				org[a] = sd.rn;
			end else if (sd.tc[2:1] == 2'(a)) begin
				org[a] = rt;
			end else begin
				org[a] = rb;
			end
		end
		res.origin_x       = org[0];
		res.origin_y       = org[1];
		res.origin_z       = org[2];
		res.half_u         = sd.hz_u ? 31'd0 :
		                     (quo_hu > DIV_W'(HALF_MAX)) ? HALF_MAX : quo_hu[30:0];
		res.half_v         = sd.hz_v ? 31'd0 :
		                     (quo_hv > DIV_W'(HALF_MAX)) ? HALF_MAX : quo_hv[30:0];
		res.normal_axis    = sd.nc;
		res.tangent_axis   = sd.tc;
		res.bitangent_axis = sd.bc;
		res.need_u         = (quo_nu > DIV_W'(lim)) ? lim : quo_nu[7:0];
		res.need_v         = (quo_nv > DIV_W'(lim)) ? lim : quo_nv[7:0];
	end

	out_item_t out_s16;

	always_ff @(posedge clk) begin
		if (en[LAST_S]) begin
			out_s16 <= res;
		end
	end

	assign out_ch.valid = vld_q[LAST_S];
	assign out_ch.data  = out_s16;

endmodule

`default_nettype wire
